>>> hw/rtl/spdc_pkg.sv
package spdc_pkg;

    localparam int MAX_SEQS_DEF     = 16;
    localparam int MAX_PATTERNS_DEF = 1024;
    localparam int COUNT_BITS_DEF   = 16;

    localparam int SYM_W   = 5;
    localparam int NSEQ_W  = 5;
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 16;
    localparam int CFG_W   = 5;
    localparam int ADDR_W  = 1;

    localparam logic [ADDR_W-1:0] REG_NUM_SEQUENCES = 1'd0;
    localparam logic [ADDR_W-1:0] REG_GAP_CODE      = 1'd1;

    // one finished column lookup
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] index;
        logic             is_new;
        logic [CNT_W-1:0] count;
        logic             full;
    } result_t;

endpackage

>>> hw/rtl/spdc_search.sv
// walks the pattern store symbol by symbol, updates the count memory unless full
module spdc_search #(
    parameter int MAX_SEQS     = spdc_pkg::MAX_SEQS_DEF,
    parameter int MAX_PATTERNS = spdc_pkg::MAX_PATTERNS_DEF,
    parameter int COUNT_BITS   = spdc_pkg::COUNT_BITS_DEF,
    parameter int SEQ_W        = (MAX_SEQS > 1) ? $clog2(MAX_SEQS) : 1,
    parameter int PAT_W        = $clog2(MAX_PATTERNS)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    input  logic [SEQ_W:0]             col_len,
    input  logic                       clear,
    output logic [SEQ_W-1:0]           buf_addr,
    input  logic [spdc_pkg::SYM_W-1:0] buf_data,
    output logic                       busy,
    output spdc_pkg::result_t          result
);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_CMP, S_CNT_RD, S_CNT_WR, S_COPY} state_t;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [spdc_pkg::SYM_W-1:0] store_mem [MAX_PATTERNS*(2**SEQ_W)];
    logic [COUNT_BITS-1:0]      count_mem [MAX_PATTERNS];

    state_t                     state_reg;
    logic [PAT_W:0]             total_reg;
    logic [PAT_W:0]             pat_reg;
    logic [SEQ_W:0]             pos_reg;
    logic                       match_reg;
    logic [spdc_pkg::SYM_W-1:0] store_q;
    logic [COUNT_BITS-1:0]      count_q;
    spdc_pkg::result_t          result_reg;

    logic [PAT_W+SEQ_W-1:0]     store_addr;
    logic                       last_sym;
    logic                       sym_eq;
    logic                       cnt_rd_en;
    logic                       cnt_wr_en;
    logic [COUNT_BITS-1:0]      cnt_wr_data;
    logic                       st_wr_en;
    logic [COUNT_BITS-1:0]      cnt_upd;

    assign store_addr = {pat_reg[PAT_W-1:0], pos_reg[SEQ_W-1:0]};
    assign buf_addr   = pos_reg[SEQ_W-1:0];
    assign last_sym   = (pos_reg + 1'b1) == col_len;
    assign sym_eq     = store_q == buf_data;
    assign cnt_upd    = (count_q == CNT_MAX) ? count_q : count_q + 1'b1;
    assign st_wr_en   = state_reg == S_COPY;
    assign cnt_rd_en  = state_reg == S_CNT_RD;
    assign cnt_wr_en  = (state_reg == S_CNT_WR) || (st_wr_en && last_sym);
    assign cnt_wr_data = (state_reg == S_CNT_WR) ? cnt_upd
                                                 : {{(COUNT_BITS-1){1'b0}}, 1'b1};

    // store memory, registered read
    always_ff @(posedge clk)
    begin
        if (st_wr_en)
        begin
            store_mem[store_addr] <= buf_data;
        end
        store_q <= store_mem[store_addr];
    end

    // count memory, registered read
    always_ff @(posedge clk)
    begin
        if (cnt_wr_en)
        begin
            count_mem[pat_reg[PAT_W-1:0]] <= cnt_wr_data;
        end
        if (cnt_rd_en)
        begin
            count_q <= count_mem[pat_reg[PAT_W-1:0]];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            total_reg  <= '0;
            pat_reg    <= '0;
            pos_reg    <= '0;
            match_reg  <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            // pattern total
            if (clear)
            begin
                total_reg <= '0;
            end
            else if (st_wr_en && last_sym)
            begin
                total_reg <= total_reg + 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    result_reg.valid <= 1'b0;
                    if (go)
                    begin
                        pat_reg   <= '0;
                        pos_reg   <= '0;
                        match_reg <= 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    // end of stored patterns
                    if (pat_reg == total_reg)
                    begin
                        pos_reg <= '0;
                        if (total_reg == (PAT_W+1)'(MAX_PATTERNS))
                        begin
                            result_reg <= '{valid: 1'b1, index: '0, is_new: 1'b0,
                                            count: '0, full: 1'b1};
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_COPY;
                        end
                    end
                    else
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    if (last_sym)
                    begin
                        if (match_reg && sym_eq)
                        begin
                            state_reg <= S_CNT_RD;
                        end
                        else
                        begin
                            pat_reg   <= pat_reg + 1'b1;
                            pos_reg   <= '0;
                            match_reg <= 1'b1;
                            state_reg <= S_READ;
                        end
                    end
                    else
                    begin
                        match_reg <= match_reg && sym_eq;
                        pos_reg   <= pos_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_CNT_RD:
                begin
                    state_reg <= S_CNT_WR;
                end
                S_CNT_WR:
                begin
                    result_reg <= '{valid: 1'b1,
                                    index: spdc_pkg::IDX_W'(pat_reg[PAT_W-1:0]),
                                    is_new: 1'b0,
                                    count: spdc_pkg::CNT_W'(cnt_upd), full: 1'b0};
                    state_reg  <= S_IDLE;
                end
                S_COPY:
                begin
                    if (last_sym)
                    begin
                        result_reg <= '{valid: 1'b1,
                                        index: spdc_pkg::IDX_W'(pat_reg[PAT_W-1:0]),
                                        is_new: 1'b1, count: spdc_pkg::CNT_W'(1),
                                        full: 1'b0};
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = state_reg != S_IDLE;
    assign result = result_reg;

    // checks
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= (PAT_W+1)'(MAX_PATTERNS))
        else $error("pattern total overflow");
    a_new_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (result_reg.valid && result_reg.is_new && !$past(clear)) |->
            total_reg == $past(total_reg) + 1'b1)
        else $error("new pattern without total increase");
    a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_reg.valid |-> !(result_reg.full && result_reg.is_new))
        else $error("full and new together");

endmodule

>>> hw/rtl/site_pattern_dedup_counter_core.sv
// a result follows the last symbol of a column once the stored patterns are compared in
// turn, each symbol read and then compared through the store's single port; on a hit the
// count is read and rewritten, a new pattern is copied in, and a full store copies nothing
// throughput: one symbol per cycle while no lookup runs; busy holds off starts
// reset: position and pattern total cleared, length 16, gap code -1; the receiver cannot stall
module site_pattern_dedup_counter_core #(
    parameter int MAX_SEQS     = spdc_pkg::MAX_SEQS_DEF,
    parameter int MAX_PATTERNS = spdc_pkg::MAX_PATTERNS_DEF,
    parameter int COUNT_BITS   = spdc_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [spdc_pkg::SYM_W-1:0]    symbol,
    input  logic                          cfg_we,
    input  logic [spdc_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [spdc_pkg::CFG_W-1:0]    cfg_data,
    output logic                          done,
    output logic [spdc_pkg::IDX_W-1:0]    pattern_index,
    output logic                          is_new,
    output logic [spdc_pkg::CNT_W-1:0]    pattern_count,
    output logic                          table_full
);

    localparam int SEQ_W = (MAX_SEQS > 1) ? $clog2(MAX_SEQS) : 1;

    logic [spdc_pkg::NSEQ_W-1:0] nseq_reg;
    logic [spdc_pkg::SYM_W-1:0]  gap_reg;
    logic [SEQ_W:0]              pos_reg;
    logic [spdc_pkg::SYM_W-1:0]  col_buf [MAX_SEQS];
    logic [SEQ_W:0]              col_len;
    logic [spdc_pkg::SYM_W-1:0]  sym_in;
    logic                        take;
    logic                        go;
    logic                        clear;
    logic [SEQ_W-1:0]            buf_addr;
    logic                        srch_busy;
    spdc_pkg::result_t           result;

    // effective column length
    always_comb
    begin
        if (nseq_reg == '0)
        begin
            col_len = (SEQ_W+1)'(1);
        end
        else if (32'(nseq_reg) > MAX_SEQS)
        begin
            col_len = (SEQ_W+1)'(MAX_SEQS);
        end
        else
        begin
            col_len = (SEQ_W+1)'(nseq_reg);
        end
    end

    assign sym_in = symbol[spdc_pkg::SYM_W-1] ? gap_reg : symbol;
    assign take   = start && !busy;
    assign go     = take && ((pos_reg + 1'b1) >= col_len);
    assign clear  = cfg_we && (cfg_addr == spdc_pkg::REG_NUM_SEQUENCES);

    // config and column position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nseq_reg <= spdc_pkg::NSEQ_W'(16);
            gap_reg  <= '1;
            pos_reg  <= '0;
        end
        else if (clear)
        begin
            nseq_reg <= cfg_data;
            pos_reg  <= '0;
        end
        else
        begin
            if (take)
            begin
                pos_reg <= go ? '0 : pos_reg + 1'b1;
            end
            if (cfg_we && cfg_addr == spdc_pkg::REG_GAP_CODE)
            begin
                gap_reg <= cfg_data;
            end
        end
    end

    // column buffer
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            col_buf[pos_reg[SEQ_W-1:0]] <= sym_in;
        end
    end

    spdc_search #(
        .MAX_SEQS     (MAX_SEQS),
        .MAX_PATTERNS (MAX_PATTERNS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .col_len  (col_len),
        .clear    (clear),
        .buf_addr (buf_addr),
        .buf_data (col_buf[buf_addr]),
        .busy     (srch_busy),
        .result   (result)
    );

    assign busy          = srch_busy;
    assign done          = result.valid;
    assign pattern_index = result.index;
    assign is_new        = result.is_new;
    assign pattern_count = result.count;
    assign table_full    = result.full;

    // checks
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < col_len || pos_reg == '0)
        else $error("column position out of range");
    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> busy)
        else $error("lookup did not start");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result repeated");

endmodule

>>> tb/sv/site_pattern_dedup_counter_core_tb.sv
`timescale 1ns / 1ps

module site_pattern_dedup_counter_core_tb;

    localparam int NPAT        = spdc_pkg::MAX_PATTERNS_DEF;
    localparam int NSEQ        = spdc_pkg::MAX_SEQS_DEF;
    localparam int STALL_LIMIT = 100000;

    typedef enum logic {ROW_SYM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                    kind;
        logic [spdc_pkg::ADDR_W-1:0]  addr;
        logic [spdc_pkg::SYM_W-1:0]   value;
        bit                           fixed;
        spdc_pkg::result_t            want;
    } stim_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [spdc_pkg::SYM_W-1:0]   symbol;
    logic                         cfg_we;
    logic [spdc_pkg::ADDR_W-1:0]  cfg_addr;
    logic [spdc_pkg::CFG_W-1:0]   cfg_data;
    logic                         done;
    logic [spdc_pkg::IDX_W-1:0]   pattern_index;
    logic                         is_new;
    logic [spdc_pkg::CNT_W-1:0]   pattern_count;
    logic                         table_full;

    site_pattern_dedup_counter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .symbol        (symbol),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .done          (done),
        .pattern_index (pattern_index),
        .is_new        (is_new),
        .pattern_count (pattern_count),
        .table_full    (table_full)
    );

    // shadow copy of the pattern store
    logic [spdc_pkg::SYM_W-1:0]   col_buf [NSEQ];
    logic [spdc_pkg::SYM_W-1:0]   pat_mem [NPAT][NSEQ];
    logic [spdc_pkg::CNT_W-1:0]   pat_cnt [NPAT];
    int unsigned                  col_pos;
    int unsigned                  pat_total;
    logic [spdc_pkg::NSEQ_W-1:0]  cur_nseq;
    logic [spdc_pkg::SYM_W-1:0]   cur_gap;

    spdc_pkg::result_t  pending_results[$];
    stim_row_t          rows[$];
    int                 mismatches;
    int                 stall_cycles;
    int                 idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // effective column length after clamping
    function automatic int unsigned col_len();
        int unsigned n;
        begin
            n = cur_nseq;
            if (n == 0) n = 1;
            if (n > NSEQ) n = NSEQ;
            return n;
        end
    endfunction

    // fold one symbol into the column, look up the pattern when complete
    function automatic bit lookup_symbol(input logic [spdc_pkg::SYM_W-1:0] sym,
                                         output spdc_pkg::result_t r);
        int unsigned n;
        int          hit;
        bit          same;
        begin
            n = col_len();
            r = '0;
            if (sym[spdc_pkg::SYM_W-1]) sym = cur_gap;
            if (col_pos >= n) col_pos = 0;
            col_buf[col_pos] = sym;
            col_pos++;
            if (col_pos < n) return 1'b0;
            col_pos = 0;
            hit = -1;
            for (int p = 0; p < pat_total && hit < 0; p++)
            begin
                same = 1'b1;
                for (int j = 0; j < n; j++)
                    if (pat_mem[p][j] != col_buf[j]) same = 1'b0;
                if (same) hit = p;
            end
            r.valid = 1'b1;
            if (hit >= 0)
            begin
                if (pat_cnt[hit] != '1) pat_cnt[hit] = pat_cnt[hit] + 1'b1;
                r.index = hit[spdc_pkg::IDX_W-1:0];
                r.count = pat_cnt[hit];
            end
            else if (pat_total < NPAT)
            begin
                for (int j = 0; j < n; j++) pat_mem[pat_total][j] = col_buf[j];
                pat_cnt[pat_total] = spdc_pkg::CNT_W'(1);
                r.index  = pat_total[spdc_pkg::IDX_W-1:0];
                r.is_new = 1'b1;
                r.count  = spdc_pkg::CNT_W'(1);
                pat_total++;
            end
            else
                r.full = 1'b1;
            return 1'b1;
        end
    endfunction

    function automatic void add_row(input row_kind_t kind,
                                    input logic [spdc_pkg::ADDR_W-1:0] addr,
                                    input logic [spdc_pkg::SYM_W-1:0] value, input bit fixed,
                                    input int idx, input bit nw, input int cnt);
        stim_row_t row;
        begin
            row.kind         = kind;
            row.addr         = addr;
            row.value        = value;
            row.fixed        = fixed;
            row.want         = '0;
            row.want.valid   = fixed;
            row.want.index   = idx[spdc_pkg::IDX_W-1:0];
            row.want.is_new  = nw;
            row.want.count   = cnt[spdc_pkg::CNT_W-1:0];
            rows.insert(rows.size(), row);
        end
    endfunction

    // register write, only once every pending result is back
    task automatic write_reg(input logic [spdc_pkg::ADDR_W-1:0] addr,
                             input logic [spdc_pkg::CFG_W-1:0] data);
        begin
            start <= 1'b0;
            while (pending_results.size() != 0) @(negedge clk);
            repeat (4) @(negedge clk);
            cfg_we   <= 1'b1;
            cfg_addr <= addr;
            cfg_data <= data;
            @(negedge clk);
            cfg_we <= 1'b0;
            if (addr == spdc_pkg::REG_NUM_SEQUENCES)
            begin
                cur_nseq  = data;
                col_pos   = 0;
                pat_total = 0;
            end
            else
                cur_gap = data;
        end
    endtask

    // one symbol request; called and returns at a falling edge
    task automatic send_symbol(input logic [spdc_pkg::SYM_W-1:0] sym, input bit fixed,
                               input spdc_pkg::result_t want);
        spdc_pkg::result_t r;
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
            start  <= 1'b1;
            symbol <= sym;
            while (busy) @(negedge clk);
            if (lookup_symbol(sym, r))
                pending_results.insert(pending_results.size(), fixed ? want : r);
            @(negedge clk);
        end
    endtask

    function automatic logic [spdc_pkg::SYM_W-1:0] rand_symbol();
        begin
            case ($urandom_range(3))
                0: return 5'($urandom_range(0, 31));
                1: return 5'h1F;
                default: return 5'($urandom_range(0, 2));
            endcase
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result idx=%0d new=%0b cnt=%0d full=%0b",
                             pattern_index, is_new, pattern_count, table_full);
            end
            else
            begin
                spdc_pkg::result_t w;
                w = pending_results.pop_front();
                if (pattern_index !== w.index || is_new !== w.is_new ||
                    pattern_count !== w.count || table_full !== w.full)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp idx=%0d new=%0b cnt=%0d full=%0b",
                                  " got %0d %0b %0d %0b"},
                                 w.index, w.is_new, w.count, w.full,
                                 pattern_index, is_new, pattern_count, table_full);
                end
            end
        end
    end

    // watchdog on cycles without any request or result
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned                  n_cols;
        spdc_pkg::result_t            none;
        logic [spdc_pkg::NSEQ_W-1:0]  nseq_pick [6];

        rst_n     = 1'b0;
        start     = 1'b0;
        symbol    = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_data  = '0;
        mismatches   = 0;
        stall_cycles = 0;
        idle_pct  = 0;
        none      = '0;
        col_pos   = 0;
        pat_total = 0;
        cur_nseq  = 5'd16;
        cur_gap   = 5'h1F;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table: clamp of zero length, gaps, hits, gap code change, discard
        add_row(ROW_CFG, spdc_pkg::REG_NUM_SEQUENCES, 5'd0, 0, 0, 0, 0);
        add_row(ROW_SYM, '0, 5'h0F, 1, 0, 1, 1);
        add_row(ROW_SYM, '0, 5'h0F, 1, 0, 0, 2);
        add_row(ROW_SYM, '0, 5'h10, 1, 1, 1, 1);
        add_row(ROW_SYM, '0, 5'h1F, 1, 1, 0, 2);
        add_row(ROW_CFG, spdc_pkg::REG_GAP_CODE, 5'h10, 0, 0, 0, 0);
        add_row(ROW_SYM, '0, 5'h1F, 1, 2, 1, 1);
        add_row(ROW_SYM, '0, 5'h10, 1, 2, 0, 2);
        add_row(ROW_SYM, '0, 5'h00, 1, 3, 1, 1);
        add_row(ROW_SYM, '0, 5'h0F, 1, 0, 0, 3);
        add_row(ROW_CFG, spdc_pkg::REG_NUM_SEQUENCES, 5'd2, 0, 0, 0, 0);
        add_row(ROW_SYM, '0, 5'h07, 0, 0, 0, 0);
        add_row(ROW_CFG, spdc_pkg::REG_NUM_SEQUENCES, 5'd2, 0, 0, 0, 0);
        add_row(ROW_SYM, '0, 5'h01, 0, 0, 0, 0);
        add_row(ROW_SYM, '0, 5'h02, 1, 0, 1, 1);
        add_row(ROW_SYM, '0, 5'h01, 0, 0, 0, 0);
        add_row(ROW_SYM, '0, 5'h02, 1, 0, 0, 2);
        add_row(ROW_SYM, '0, 5'h10, 0, 0, 0, 0);
        add_row(ROW_SYM, '0, 5'h0F, 1, 1, 1, 1);
        add_row(ROW_CFG, spdc_pkg::REG_GAP_CODE, 5'h1F, 0, 0, 0, 0);
        add_row(ROW_CFG, spdc_pkg::REG_NUM_SEQUENCES, 5'd31, 0, 0, 0, 0);
        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
                write_reg(rows[i].addr, rows[i].value);
            else
                send_symbol(rows[i].value, rows[i].fixed, rows[i].want);
        end

        // random phases with different sender idling
        nseq_pick[0] = 5'd16;
        nseq_pick[1] = 5'd1;
        nseq_pick[2] = 5'd31;
        nseq_pick[3] = 5'd2;
        nseq_pick[4] = 5'd0;
        nseq_pick[5] = 5'd4;
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 22 : (ph == 1) ? 57 : 0;
            for (int s = 0; s < 4; s++)
            begin
                write_reg(spdc_pkg::REG_NUM_SEQUENCES,
                          (s == 3) ? 5'($urandom_range(0, 31)) : nseq_pick[(ph * 2 + s) % 6]);
                write_reg(spdc_pkg::REG_GAP_CODE,
                          (s == 0) ? 5'h10 : (s == 1) ? 5'h1F : 5'($urandom_range(16, 31)));
                n_cols = 0;
                for (int k = 0; k < 70 || n_cols < 8; k++)
                begin
                    send_symbol(rand_symbol(), 0, none);
                    if (col_pos == 0) n_cols++;
                end
            end
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/spdc_pkg.sv
hw/rtl/spdc_search.sv
hw/rtl/site_pattern_dedup_counter_core.sv
tb/sv/site_pattern_dedup_counter_core_tb.sv
